/* rtl/i2cw_pkg.sv */
`timescale 1ns / 1ps

package i2cw_pkg;

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_TICKS    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT    = 2'd2;

	localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'd120;
	localparam logic [15:0] PHASE_TICKS_RST    = 16'd2;
	localparam logic [7:0]  ACK_TIMEOUT_RST    = 8'd250;

	localparam int TIMER_WIDTH_DEF = 16;

	// control byte sent after the address
	localparam logic [7:0] CTRL_COMMAND = 8'h00;
	localparam logic [7:0] CTRL_DATA    = 8'h40;

	// header step: which byte is on the bus; the next acknowledge advances from it
	localparam logic [1:0] HDR_ADDR = 2'd0;
	localparam logic [1:0] HDR_CTRL = 2'd1;
	localparam logic [1:0] HDR_DATA = 2'd2;

endpackage

/* rtl/i2cw_tick_if.sv */
`timescale 1ns / 1ps

interface i2cw_tick_if ();
	logic       valid;
	logic       ready;
	logic       req_valid;
	logic       mode;
	logic [7:0] payload;
	logic       opens;
	logic       closes;
	logic       sda_in;

	modport source (output valid, req_valid, mode, payload, opens, closes, sda_in,
		input ready);
	modport sink (input valid, req_valid, mode, payload, opens, closes, sda_in,
		output ready);
endinterface

/* rtl/i2cw_result_if.sv */
`timescale 1ns / 1ps

interface i2cw_result_if ();
	logic valid;
	logic ready;
	logic scl_out;
	logic sda_out;
	logic req_accept;
	logic idle;
	logic byte_done;
	logic ack_fail;

	modport source (output valid, scl_out, sda_out, req_accept, idle, byte_done, ack_fail,
		input ready);
	modport sink (input valid, scl_out, sda_out, req_accept, idle, byte_done, ack_fail,
		output ready);
endinterface

/* rtl/i2cw_cfg_if.sv */
`timescale 1ns / 1ps

interface i2cw_cfg_if import i2cw_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/i2c_master_write_engine.sv */
`timescale 1ns / 1ps
// channel   dir   contents
// tick      in    req_valid, mode, payload, opens, closes, sda_in (one bus tick)
// result    out   scl_out, sda_out, req_accept, idle, byte_done, ack_fail
// cfg       in    index, data: device_address, phase_ticks, ack_timeout
//
// One tick is taken per clock; the bus sequencer updates in the same cycle and
// its result lands in the output register, visible in the cycle after acceptance.
// tick.ready drops only while the output register is full and result stalls;
// a waiting result holds the next tick for as long as it is not taken.
// Reset puts the bus released in idle with all counters cleared; cfg is always ready.

module i2c_master_write_engine import i2cw_pkg::*; #(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	i2cw_tick_if.sink    tick,
	i2cw_result_if.source result,
	i2cw_cfg_if.sink     cfg
);

	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_STA1 = 4'd1;
	localparam logic [3:0] PH_STA2 = 4'd2;
	localparam logic [3:0] PH_BLO  = 4'd3;
	localparam logic [3:0] PH_BHI  = 4'd4;
	localparam logic [3:0] PH_ALO  = 4'd5;
	localparam logic [3:0] PH_AHI  = 4'd6;
	localparam logic [3:0] PH_HOLD = 4'd7;
	localparam logic [3:0] PH_STO1 = 4'd8;
	localparam logic [3:0] PH_STO2 = 4'd9;
	localparam logic [3:0] PH_STO3 = 4'd10;

	// configuration
	logic [7:0]  dev_addr_q;
	logic [15:0] phase_ticks_q;
	logic [7:0]  ack_timeout_q;

	// sequencer state
	logic [3:0]             phase_q, phase_nx;
	logic [1:0]             hdr_q, hdr_nx;
	logic [3:0]             bit_cnt_q, bit_cnt_nx;
	logic [7:0]             shift_q, shift_nx;
	logic [7:0]             held_payload_q, held_payload_nx;
	logic                   held_mode_q, held_mode_nx;
	logic                   held_closes_q, held_closes_nx;
	logic [TIMER_WIDTH-1:0] timer_q, timer_nx;
	logic [7:0]             ack_wait_q, ack_wait_nx;

	// result register
	logic res_valid_q;
	logic scl_q, sda_q, acc_q, idle_q, done_q, fail_q;

	logic scl_c, sda_c, acc_c, done_c, fail_c;
	logic tick_acc;

	logic [TIMER_WIDTH-1:0] period_raw, period;
	logic [TIMER_WIDTH:0]   timer_inc;
	logic                   half_end;
	logic [3:0]             bit_cnt_inc;

	assign cfg.ready  = 1'b1;
	assign tick.ready = !res_valid_q || result.ready;
	assign tick_acc   = tick.valid && tick.ready;

	assign period_raw  = TIMER_WIDTH'(phase_ticks_q);
	assign period      = (period_raw == '0) ? TIMER_WIDTH'(1) : period_raw;
	assign timer_inc   = {1'b0, timer_q} + (TIMER_WIDTH+1)'(1);
	assign half_end    = timer_inc >= {1'b0, period};
	assign bit_cnt_inc = bit_cnt_q + 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q    <= DEVICE_ADDRESS_RST;
			phase_ticks_q <= PHASE_TICKS_RST;
			ack_timeout_q <= ACK_TIMEOUT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DEVICE_ADDRESS: dev_addr_q    <= cfg.data[7:0];
				REG_PHASE_TICKS:    phase_ticks_q <= cfg.data[15:0];
				REG_ACK_TIMEOUT:    ack_timeout_q <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// line drive follows the phase held at the start of the tick
	always_comb begin
		scl_c = 1'b1;
		sda_c = 1'b1;
		case (phase_q)
			PH_STA2: sda_c = 1'b0;
			PH_BLO: begin
				scl_c = 1'b0;
				sda_c = shift_q[7];
			end
			PH_BHI:  sda_c = shift_q[7];
			PH_ALO:  scl_c = 1'b0;
			PH_HOLD: scl_c = 1'b0;
			PH_STO1: begin
				scl_c = 1'b0;
				sda_c = 1'b0;
			end
			PH_STO2: sda_c = 1'b0;
			default: ;
		endcase
	end

	always_comb begin
		phase_nx        = phase_q;
		hdr_nx          = hdr_q;
		bit_cnt_nx      = bit_cnt_q;
		shift_nx        = shift_q;
		held_payload_nx = held_payload_q;
		held_mode_nx    = held_mode_q;
		held_closes_nx  = held_closes_q;
		timer_nx        = timer_q;
		ack_wait_nx     = ack_wait_q;
		acc_c           = 1'b0;
		done_c          = 1'b0;
		fail_c          = 1'b0;

		case (phase_q)
			PH_IDLE: begin
				if (tick.req_valid && tick.opens) begin
					acc_c           = 1'b1;
					held_payload_nx = tick.payload;
					held_mode_nx    = tick.mode;
					held_closes_nx  = tick.closes;
					hdr_nx          = HDR_ADDR;
					phase_nx        = PH_STA1;
					timer_nx        = '0;
					bit_cnt_nx      = '0;
				end
			end
			PH_HOLD: begin
				if (tick.req_valid) begin
					acc_c           = 1'b1;
					held_payload_nx = tick.payload;
					held_mode_nx    = tick.mode;
					held_closes_nx  = tick.closes;
					timer_nx        = '0;
					bit_cnt_nx      = '0;
					if (tick.opens) begin
						hdr_nx   = HDR_ADDR;
						phase_nx = PH_STA1;
					end else begin
						shift_nx = tick.payload;
						hdr_nx   = HDR_DATA;
						phase_nx = PH_BLO;
					end
				end
			end
			// start, stop: two half periods, bit counter marks the second
			PH_STA1, PH_STA2, PH_STO1, PH_STO2, PH_STO3: begin
				timer_nx = half_end ? '0 : timer_inc[TIMER_WIDTH-1:0];
				if (half_end) begin
					if (bit_cnt_q == 4'd0) begin
						bit_cnt_nx = 4'd1;
					end else begin
						bit_cnt_nx = '0;
						case (phase_q)
							PH_STA1: phase_nx = PH_STA2;
							PH_STA2: begin
								shift_nx = dev_addr_q;
								phase_nx = PH_BLO;
							end
							PH_STO1: phase_nx = PH_STO2;
							PH_STO2: phase_nx = PH_STO3;
							default: begin
								phase_nx = PH_IDLE;
								hdr_nx   = HDR_ADDR;
							end
						endcase
					end
				end
			end
			PH_BLO: begin
				timer_nx = half_end ? '0 : timer_inc[TIMER_WIDTH-1:0];
				if (half_end) begin
					phase_nx = PH_BHI;
				end
			end
			PH_BHI: begin
				timer_nx = half_end ? '0 : timer_inc[TIMER_WIDTH-1:0];
				if (half_end) begin
					shift_nx = {shift_q[6:0], 1'b0};
					if (bit_cnt_inc >= 4'd8) begin
						phase_nx   = PH_ALO;
						bit_cnt_nx = '0;
					end else begin
						phase_nx   = PH_BLO;
						bit_cnt_nx = bit_cnt_inc;
					end
				end
			end
			PH_ALO: begin
				timer_nx = half_end ? '0 : timer_inc[TIMER_WIDTH-1:0];
				if (half_end) begin
					ack_wait_nx = '0;
					phase_nx    = PH_AHI;
					bit_cnt_nx  = '0;
				end
			end
			PH_AHI: begin
				if (!tick.sda_in) begin
					timer_nx   = '0;
					bit_cnt_nx = '0;
					case (hdr_q)
						HDR_ADDR: begin
							shift_nx = held_mode_q ? CTRL_DATA : CTRL_COMMAND;
							hdr_nx   = HDR_CTRL;
							phase_nx = PH_BLO;
						end
						HDR_CTRL: begin
							shift_nx = held_payload_q;
							hdr_nx   = HDR_DATA;
							phase_nx = PH_BLO;
						end
						default: begin
							done_c   = 1'b1;
							phase_nx = held_closes_q ? PH_STO1 : PH_HOLD;
						end
					endcase
				end else if (ack_wait_q >= ack_timeout_q) begin
					// timed out: stop the bus and drop the transaction
					fail_c     = 1'b1;
					phase_nx   = PH_STO1;
					timer_nx   = '0;
					bit_cnt_nx = '0;
				end else begin
					ack_wait_nx = ack_wait_q + 8'd1;
				end
			end
			default: begin
				phase_nx   = PH_IDLE;
				hdr_nx     = HDR_ADDR;
				timer_nx   = '0;
				bit_cnt_nx = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			hdr_q          <= HDR_ADDR;
			bit_cnt_q      <= '0;
			shift_q        <= '0;
			held_payload_q <= '0;
			held_mode_q    <= 1'b0;
			held_closes_q  <= 1'b0;
			timer_q        <= '0;
			ack_wait_q     <= '0;
		end else if (tick_acc) begin
			phase_q        <= phase_nx;
			hdr_q          <= hdr_nx;
			bit_cnt_q      <= bit_cnt_nx;
			shift_q        <= shift_nx;
			held_payload_q <= held_payload_nx;
			held_mode_q    <= held_mode_nx;
			held_closes_q  <= held_closes_nx;
			timer_q        <= timer_nx;
			ack_wait_q     <= ack_wait_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tick_acc) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			scl_q  <= scl_c;
			sda_q  <= sda_c;
			acc_q  <= acc_c;
			idle_q <= (phase_q == PH_IDLE);
			done_q <= done_c;
			fail_q <= fail_c;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.scl_out    = scl_q;
	assign result.sda_out    = sda_q;
	assign result.req_accept = acc_q;
	assign result.idle       = idle_q;
	assign result.byte_done  = done_q;
	assign result.ack_fail   = fail_q;

endmodule

/* sim/i2c_master_write_engine_tb.sv */
`timescale 1ns / 1ps

module i2c_master_write_engine_tb;
	import i2cw_pkg::*;

	localparam int CLK_PERIOD    = 4;
	localparam int RESET_CYCLES  = 9;
	localparam int SETTLE_CYCLES = 10;
	localparam int QUIET_LIMIT   = 2000;
	localparam int TICKS_PER_SET = 80;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START_HI,
		PH_START_LO,
		PH_BIT_LO,
		PH_BIT_HI,
		PH_ACK_LO,
		PH_ACK_HI,
		PH_HOLD,
		PH_STOP_LO,
		PH_STOP_MID,
		PH_STOP_HI
	} bus_phase_e;

	typedef enum int {
		STALL_NONE,
		STALL_SCATTER,
		STALL_HEAVY,
		STALL_EVERY_FIFTH
	} stall_style_e;

	typedef struct packed {
		logic       req_valid;
		logic       mode;
		logic [7:0] payload;
		logic       opens;
		logic       closes;
		logic       sda_in;
	} bus_tick_t;

	typedef struct packed {
		logic scl;
		logic sda;
		logic accept;
		logic idle;
		logic done;
		logic fail;
	} line_state_t;

	logic clk;
	logic arst_n;

	i2cw_tick_if   tick ();
	i2cw_result_if result ();
	i2cw_cfg_if    cfg ();

	i2c_master_write_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.result (result),
		.cfg    (cfg)
	);

	// shadow of the bus sequencer
	logic [7:0]  reg_addr;
	logic [15:0] reg_period;
	logic [7:0]  reg_timeout;
	bus_phase_e  bus_phase;
	logic [1:0]  hdr_step;
	logic [3:0]  bit_cnt;
	logic [7:0]  shift_reg;
	logic [7:0]  held_byte;
	logic        held_mode;
	logic        held_closes;
	logic [15:0] phase_cnt;
	logic [7:0]  ack_cnt;

	line_state_t line_q[$];

	int          errors;
	int unsigned ticks_sent;
	int unsigned burst_left;
	int unsigned ack_high_left;
	bit          ack_refuse;
	bit          taken;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic logic half_elapsed();
		logic [16:0] half;
		half = (reg_period == '0) ? 17'd1 : {1'b0, reg_period};
		if ({1'b0, phase_cnt} + 17'd1 >= half) begin
			phase_cnt = '0;
			return 1'b1;
		end
		phase_cnt = phase_cnt + 16'd1;
		return 1'b0;
	endfunction

	// start and stop phases span two half periods
	function automatic logic full_elapsed();
		if (!half_elapsed())
			return 1'b0;
		if (bit_cnt == 4'd0) begin
			bit_cnt = 4'd1;
			return 1'b0;
		end
		bit_cnt = 4'd0;
		return 1'b1;
	endfunction

	function automatic void goto_phase(bus_phase_e ph);
		bus_phase = ph;
		phase_cnt = '0;
		bit_cnt   = '0;
	endfunction

	function automatic line_state_t bus_step(bus_tick_t t);
		line_state_t r;
		r      = '0;
		r.scl  = 1'b1;
		r.sda  = 1'b1;
		r.idle = (bus_phase == PH_IDLE);
		case (bus_phase)
			PH_START_LO: r.sda = 1'b0;
			PH_BIT_LO: begin
				r.scl = 1'b0;
				r.sda = shift_reg[7];
			end
			PH_BIT_HI: r.sda = shift_reg[7];
			PH_ACK_LO, PH_HOLD: r.scl = 1'b0;
			PH_STOP_LO: begin
				r.scl = 1'b0;
				r.sda = 1'b0;
			end
			PH_STOP_MID: r.sda = 1'b0;
			default: ;
		endcase

		case (bus_phase)
			PH_IDLE: if (t.req_valid && t.opens) begin
				held_byte   = t.payload;
				held_mode   = t.mode;
				held_closes = t.closes;
				r.accept    = 1'b1;
				hdr_step    = HDR_ADDR;
				goto_phase(PH_START_HI);
			end
			PH_HOLD: if (t.req_valid) begin
				held_byte   = t.payload;
				held_mode   = t.mode;
				held_closes = t.closes;
				r.accept    = 1'b1;
				if (t.opens) begin
					hdr_step = HDR_ADDR;
					goto_phase(PH_START_HI);
				end else begin
					shift_reg = t.payload;
					hdr_step  = HDR_DATA;
					goto_phase(PH_BIT_LO);
				end
			end
			PH_START_HI: if (full_elapsed())
				goto_phase(PH_START_LO);
			PH_START_LO: if (full_elapsed()) begin
				shift_reg = reg_addr;
				goto_phase(PH_BIT_LO);
			end
			PH_BIT_LO: if (half_elapsed())
				bus_phase = PH_BIT_HI;
			PH_BIT_HI: if (half_elapsed()) begin
				shift_reg = shift_reg << 1;
				bit_cnt   = bit_cnt + 4'd1;
				if (bit_cnt >= 4'd8)
					goto_phase(PH_ACK_LO);
				else
					bus_phase = PH_BIT_LO;
			end
			PH_ACK_LO: if (half_elapsed()) begin
				ack_cnt = '0;
				goto_phase(PH_ACK_HI);
			end
			PH_ACK_HI: begin
				if (!t.sda_in) begin
					case (hdr_step)
						HDR_ADDR: begin
							shift_reg = held_mode ? CTRL_DATA : CTRL_COMMAND;
							hdr_step  = HDR_CTRL;
							goto_phase(PH_BIT_LO);
						end
						HDR_CTRL: begin
							shift_reg = held_byte;
							hdr_step  = HDR_DATA;
							goto_phase(PH_BIT_LO);
						end
						default: begin
							r.done = 1'b1;
							goto_phase(held_closes ? PH_STOP_LO : PH_HOLD);
						end
					endcase
				end else if (ack_cnt >= reg_timeout) begin
					r.fail = 1'b1;
					goto_phase(PH_STOP_LO);
				end else begin
					ack_cnt = ack_cnt + 8'd1;
				end
			end
			PH_STOP_LO: if (full_elapsed())
				goto_phase(PH_STOP_MID);
			PH_STOP_MID: if (full_elapsed())
				goto_phase(PH_STOP_HI);
			PH_STOP_HI: if (full_elapsed()) begin
				goto_phase(PH_IDLE);
				hdr_step = HDR_ADDR;
			end
			default: begin
				goto_phase(PH_IDLE);
				hdr_step = HDR_ADDR;
			end
		endcase
		return r;
	endfunction

	// play the slave: acknowledge, at times after a short delay, or refuse to
	function automatic logic pick_sda();
		if (bus_phase != PH_ACK_HI)
			return logic'($urandom_range(0, 1));
		if (ack_refuse)
			return 1'b1;
		if (ack_high_left != 0) begin
			ack_high_left--;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// tick that carries no request the block may take
	function automatic bus_tick_t filler_tick();
		bus_tick_t t;
		t.req_valid = ($urandom_range(0, 9) == 0) && (bus_phase != PH_HOLD);
		t.mode      = 1'($urandom_range(0, 1));
		t.payload   = 8'($urandom);
		t.opens     = (bus_phase != PH_IDLE) && ($urandom_range(0, 1) == 1);
		t.closes    = 1'($urandom_range(0, 1));
		t.sda_in    = pick_sda();
		return t;
	endfunction

	task automatic send_tick(input bus_tick_t t);
		bus_phase_e  prev;
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				tick.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		burst_left--;
		tick.valid     <= 1'b1;
		tick.req_valid <= t.req_valid;
		tick.mode      <= t.mode;
		tick.payload   <= t.payload;
		tick.opens     <= t.opens;
		tick.closes    <= t.closes;
		tick.sda_in    <= t.sda_in;
		@(posedge clk);
		while (!tick.ready) @(posedge clk);
		prev = bus_phase;
		line_q.push_back(bus_step(t));
		taken = line_q[$].accept;
		ticks_sent++;
		if (bus_phase == PH_ACK_HI && prev != PH_ACK_HI)
			ack_high_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
	endtask

	// offer one request; if taken, run the bus until it holds or stops
	task automatic run_request(input logic opens, input logic closes, input logic mode,
		input logic [7:0] payload, input bit refuse);
		bus_tick_t t;
		ack_refuse  = refuse;
		t.req_valid = 1'b1;
		t.mode      = mode;
		t.payload   = payload;
		t.opens     = opens;
		t.closes    = closes;
		t.sda_in    = pick_sda();
		send_tick(t);
		if (taken) begin
			while (bus_phase != PH_HOLD && bus_phase != PH_IDLE)
				send_tick(filler_tick());
		end
		ack_refuse = 1'b0;
	endtask

	task automatic close_bus();
		while (bus_phase != PH_IDLE) begin
			if (bus_phase == PH_HOLD)
				run_request(1'b0, 1'b1, 1'($urandom_range(0, 1)), 8'($urandom), 1'b0);
			else
				send_tick(filler_tick());
		end
	endtask

	task automatic drain_results();
		tick.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (line_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			REG_DEVICE_ADDRESS: reg_addr    = data[7:0];
			REG_PHASE_TICKS:    reg_period  = data;
			REG_ACK_TIMEOUT:    reg_timeout = data[7:0];
			default: ;
		endcase
	endtask

	// upper data bits are junk for the 8-bit registers
	task automatic load_regs(input logic [7:0] addr, input logic [15:0] period,
		input logic [7:0] tmo);
		drain_results();
		write_reg(REG_UNUSED, 16'($urandom));
		write_reg(REG_DEVICE_ADDRESS, {8'($urandom), addr});
		write_reg(REG_PHASE_TICKS, period);
		write_reg(REG_ACK_TIMEOUT, {8'($urandom), tmo});
		cfg.valid <= 1'b0;
	endtask

	task automatic test_ignored_requests();
		bus_tick_t t;
		t         = '0;
		t.req_valid = 1'b1;
		t.mode    = 1'b1;
		t.payload = 8'hFF;
		t.closes  = 1'b1;
		t.sda_in  = 1'b1;
		send_tick(t);
		t = '0;
		send_tick(t);
	endtask

	task automatic test_command_then_data();
		run_request(1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
		run_request(1'b0, 1'b0, 1'b1, 8'hFF, 1'b0);
		run_request(1'b0, 1'b1, 1'b1, 8'hA5, 1'b0);
		close_bus();
	endtask

	task automatic test_repeated_start();
		run_request(1'b1, 1'b0, 1'b1, 8'h3C, 1'b0);
		run_request(1'b1, 1'b1, 1'b0, 8'hC3, 1'b0);
		close_bus();
	endtask

	task automatic test_ack_timeout();
		bus_tick_t t;
		load_regs(8'hFF, 16'd1, 8'd0);
		run_request(1'b1, 1'b0, 1'b0, 8'h80, 1'b1);
		close_bus();
		// a continuation after the drop finds the bus idle
		t           = '0;
		t.req_valid = 1'b1;
		t.payload   = 8'h55;
		send_tick(t);
		load_regs(8'h00, 16'd1, 8'd255);
		run_request(1'b1, 1'b1, 1'b1, 8'h01, 1'b1);
		close_bus();
	endtask

	task automatic test_zero_period();
		load_regs(8'h78, 16'd0, 8'd3);
		run_request(1'b1, 1'b0, 1'b1, 8'h7E, 1'b0);
		run_request(1'b0, 1'b1, 1'b0, 8'h81, 1'b0);
		close_bus();
	endtask

	// the longest period cannot finish a byte here: shorten it mid start
	task automatic test_long_period();
		bus_tick_t t;
		load_regs(8'($urandom), 16'hFFFF, 8'd250);
		t           = '0;
		t.req_valid = 1'b1;
		t.payload   = 8'($urandom);
		t.opens     = 1'b1;
		t.closes    = 1'b1;
		t.sda_in    = pick_sda();
		send_tick(t);
		repeat (60) send_tick(filler_tick());
		load_regs(reg_addr, 16'd1, 8'd250);
		close_bus();
	endtask

	task automatic test_random_traffic(input logic [7:0] addr, input logic [15:0] period,
		input logic [7:0] tmo);
		int unsigned stop_at;
		load_regs(addr, period, tmo);
		stop_at = ticks_sent + TICKS_PER_SET;
		while (ticks_sent < stop_at) begin
			if (bus_phase != PH_IDLE && bus_phase != PH_HOLD)
				send_tick(filler_tick());
			else if ($urandom_range(0, 4) == 0)
				send_tick(filler_tick());
			else
				run_request(bus_phase == PH_IDLE ? ($urandom_range(0, 9) != 0)
					: ($urandom_range(0, 3) == 0),
					$urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)), 8'($urandom),
					$urandom_range(0, 15) == 0);
		end
		close_bus();
	endtask

	function automatic string field_name(int unsigned bitpos);
		case (bitpos)
			5: return "scl_out";
			4: return "sda_out";
			3: return "req_accept";
			2: return "idle";
			1: return "byte_done";
			default: return "ack_fail";
		endcase
	endfunction

	always @(posedge clk) begin
		line_state_t want;
		line_state_t got;
		if (arst_n && result.valid && result.ready) begin
			got = {result.scl_out, result.sda_out, result.req_accept, result.idle,
				result.byte_done, result.ack_fail};
			if (line_q.size() == 0) begin
				$display("%0t: unexpected result %b, expected none", $time, got);
				errors++;
			end else begin
				want = line_q.pop_front();
				for (int i = 5; i >= 0; i--) begin
					if (got[i] !== want[i]) begin
						$display("%0t: %s expected %b actual %b", $time, field_name(i),
							want[i], got[i]);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		stall_style_e style;
		int unsigned  style_left;
		int unsigned  cnt;
		logic [7:0]   lfsr;
		result.ready <= 1'b0;
		style_left = 0;
		cnt        = 0;
		lfsr       = 8'($urandom) | 8'h01;
		forever begin
			@(posedge clk);
			if (style_left == 0) begin
				style      = stall_style_e'($urandom_range(0, 3));
				style_left = $urandom_range(20, 120);
			end
			style_left--;
			cnt++;
			lfsr = {lfsr[6:0], lfsr[7] ^ lfsr[5] ^ lfsr[4] ^ lfsr[3]};
			case (style)
				STALL_NONE:    result.ready <= 1'b1;
				STALL_SCATTER: result.ready <= lfsr[0];
				STALL_HEAVY:   result.ready <= (lfsr[2:0] == 3'd0);
				default:       result.ready <= (cnt % 5 != 0);
			endcase
		end
	end

	// end the run when no channel moves for too long
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((tick.valid && tick.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("i2c_master_write_engine: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		tick.valid     <= 1'b0;
		tick.req_valid <= 1'b0;
		tick.mode      <= 1'b0;
		tick.payload   <= '0;
		tick.opens     <= 1'b0;
		tick.closes    <= 1'b0;
		tick.sda_in    <= 1'b1;
		cfg.valid      <= 1'b0;
		cfg.index      <= '0;
		cfg.data       <= '0;
		reg_addr      = DEVICE_ADDRESS_RST;
		reg_period    = PHASE_TICKS_RST;
		reg_timeout   = ACK_TIMEOUT_RST;
		bus_phase     = PH_IDLE;
		hdr_step      = HDR_ADDR;
		bit_cnt       = '0;
		shift_reg     = '0;
		held_byte     = '0;
		held_mode     = 1'b0;
		held_closes   = 1'b0;
		phase_cnt     = '0;
		ack_cnt       = '0;
		errors        = 0;
		ticks_sent    = 0;
		burst_left    = 0;
		ack_high_left = 0;
		ack_refuse    = 1'b0;
		taken         = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ignored_requests();
		test_command_then_data();
		test_repeated_start();
		test_ack_timeout();
		test_zero_period();
		test_long_period();
		test_random_traffic(8'($urandom), 16'd2, 8'd250);
		test_random_traffic(8'hFF, 16'd1, 8'd0);
		test_random_traffic(8'h00, 16'd0, 8'd255);
		test_random_traffic(8'($urandom), 16'd3, 8'($urandom_range(1, 4)));

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("i2c_master_write_engine: match");
		else
			$display("i2c_master_write_engine: mismatch");
		$finish;
	end

endmodule
